// ===== rtl/assert_macros.svh =====
// assertion macros shared by the mixer rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, off while reset is held
`define MVM_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("mixer assertion failed");

// clocked assertion, checked in reset too
`define MVM_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("mixer assertion failed");

`endif

// ===== rtl/mvm_pkg.sv =====
// package: types, codes and defaults of the voice mixer
`default_nettype none
package mvm_pkg;

  localparam int NUM_VOICES_DEF    = 64;
  localparam int STREAM_VOICES_DEF = 16;
  localparam int RING_FRAMES_DEF   = 4096;
  localparam int SAMPLE_FRAMES_DEF = 65536;

  typedef enum logic [2:0] {
    CMD_WRITE = 3'd0,
    CMD_START = 3'd1,
    CMD_STOP  = 3'd2,
    CMD_PUSH  = 3'd3,
    CMD_MIX   = 3'd4
  } cmd_t;

  localparam logic [1:0] STAT_MIXED   = 2'd0;
  localparam logic [1:0] STAT_PUSHED  = 2'd1;
  localparam logic [1:0] STAT_DROPPED = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EXEC,
    ST_FLAG,
    ST_FETCH,
    ST_LERP,
    ST_ROUND,
    ST_MUL,
    ST_ACC,
    ST_WRAP,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic mix_init;
    logic next_voice;
    logic end_voice;
    logic fetch;
    logic lerp;
    logic round;
    logic mul;
    logic acc;
    logic wrap;
    logic emit;
  } dp_ctl_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic       play;
    logic       stream;
    logic       ended;
    logic       empty;
    logic       stop_req;
    logic       last;
    logic       over;
    logic       loop;
    logic       wrap_more;
  } dp_stat_t;

  typedef struct packed {
    logic [15:0] base;
    logic [16:0] len;
    logic [18:0] step;
    logic [15:0] gain;
    logic [15:0] pan_l;
    logic [15:0] pan_r;
  } voice_t;

endpackage
`default_nettype wire

// ===== rtl/mvm_ctrl.sv =====
// controller: command sequencing and per-voice mix walk
`default_nettype none
`include "assert_macros.svh"
module mvm_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  output mvm_pkg::dp_ctl_t  ctl,
  input  mvm_pkg::dp_stat_t stat
);
  import mvm_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    ctl       = '0;
    state_nxt = state_r;
    busy      = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          ctl.load  = 1'b1;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (stat.cmd == CMD_MIX) begin
          ctl.mix_init = 1'b1;
          state_nxt    = ST_FLAG;
        end else begin
          ctl.exec  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_FLAG: begin
        if (stat.play) begin
          state_nxt = ST_FETCH;
        end else if (stat.last) begin
          state_nxt = ST_OUT;
        end else begin
          ctl.next_voice = 1'b1;
        end
      end
      ST_FETCH: begin
        ctl.fetch = 1'b1;
        if (stat.stream ? stat.empty : stat.ended) begin
          ctl.end_voice = !stat.stream || stat.stop_req;
          if (stat.last) begin
            state_nxt = ST_OUT;
          end else begin
            ctl.next_voice = 1'b1;
            state_nxt      = ST_FLAG;
          end
        end else begin
          state_nxt = ST_LERP;
        end
      end
      ST_LERP: begin
        ctl.lerp  = 1'b1;
        state_nxt = ST_ROUND;
      end
      ST_ROUND: begin
        ctl.round = 1'b1;
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        ctl.mul   = 1'b1;
        state_nxt = ST_ACC;
      end
      ST_ACC: begin
        ctl.acc = 1'b1;
        if (!stat.stream && stat.over && stat.loop) begin
          state_nxt = ST_WRAP;
        end else begin
          ctl.end_voice = !stat.stream && stat.over;
          if (stat.last) begin
            state_nxt = ST_OUT;
          end else begin
            ctl.next_voice = 1'b1;
            state_nxt      = ST_FLAG;
          end
        end
      end
      ST_WRAP: begin
        ctl.wrap = 1'b1;
        if (!stat.wrap_more) begin
          if (stat.last) begin
            state_nxt = ST_OUT;
          end else begin
            ctl.next_voice = 1'b1;
            state_nxt      = ST_FLAG;
          end
        end
      end
      ST_OUT: begin
        ctl.emit  = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  `MVM_ASSERT(a_accept_goes_busy, clk, rst_n, start && !busy |=> busy)

endmodule
`default_nettype wire

// ===== rtl/mvm_dp.sv =====
// datapath: memories, voice state, interpolation, scaling and mix sums
`default_nettype none
`include "assert_macros.svh"
module mvm_dp #(
  parameter int NUM_VOICES    = mvm_pkg::NUM_VOICES_DEF,
  parameter int STREAM_VOICES = mvm_pkg::STREAM_VOICES_DEF,
  parameter int RING_FRAMES   = mvm_pkg::RING_FRAMES_DEF,
  parameter int SAMPLE_FRAMES = mvm_pkg::SAMPLE_FRAMES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  mvm_pkg::dp_ctl_t   ctl,
  output mvm_pkg::dp_stat_t  stat,
  input  logic [2:0]         in_cmd,
  input  logic [5:0]         in_voice,
  input  logic [15:0]        in_address,
  input  logic signed [15:0] in_sample_left,
  input  logic signed [15:0] in_sample_right,
  input  logic [16:0]        in_length_frames,
  input  logic [18:0]        in_step,
  input  logic [15:0]        in_gain,
  input  logic [15:0]        in_pan_left,
  input  logic [15:0]        in_pan_right,
  input  logic               in_stereo,
  input  logic               in_looping,
  output logic               out_valid,
  output logic signed [15:0] out_mix_left,
  output logic signed [15:0] out_mix_right,
  output logic               out_clipped,
  output logic [6:0]         out_active_voices,
  output logic [1:0]         out_status
);
  import mvm_pkg::*;

  localparam int VI_W     = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
  localparam int STREAM_N = (STREAM_VOICES > 0) ? STREAM_VOICES : 1;
  localparam int STREAM_FIRST =
    (NUM_VOICES > STREAM_VOICES) ? NUM_VOICES - STREAM_VOICES : 0;
  localparam int SI_W     = (STREAM_N > 1) ? $clog2(STREAM_N) : 1;
  localparam int RA_W     = $clog2(RING_FRAMES);
  localparam int RP_W     = RA_W + 1;
  localparam int RM_W     = SI_W + RA_W;
  localparam int SA_W     = $clog2(SAMPLE_FRAMES);
  localparam int SUM_W    = (SA_W > 17) ? SA_W + 1 : 18;
  localparam int CNT_W    = $clog2(NUM_VOICES + 1);
  localparam int ACC_W    = 50 + VI_W;

  // latched command
  logic [2:0]  cmd_r;
  logic [5:0]  voice_r;
  logic [15:0] addr_r, left_r, right_r, gain_r, panl_r, panr_r;
  logic [16:0] len_r;
  logic [18:0] step_r;
  logic        stereo_in_r, loop_in_r;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r       <= in_cmd;
      voice_r     <= in_voice;
      addr_r      <= in_address;
      left_r      <= in_sample_left;
      right_r     <= in_sample_right;
      len_r       <= in_length_frames;
      step_r      <= in_step;
      gain_r      <= in_gain;
      panl_r      <= in_pan_left;
      panr_r      <= in_pan_right;
      stereo_in_r <= in_stereo;
      loop_in_r   <= in_looping;
    end
  end

  // voice state in flops
  logic [NUM_VOICES-1:0] play_r, stereo_r, loop_r, stop_r;
  logic [CNT_W-1:0]      cnt_r;
  logic [VI_W-1:0]       idx_r;
  logic [RP_W-1:0]       rd_ptr_r [STREAM_N];
  logic [RP_W-1:0]       wr_ptr_r [STREAM_N];

  // memories
  logic [31:0] smem     [SAMPLE_FRAMES];
  logic [31:0] ring     [STREAM_N*RING_FRAMES];
  voice_t      par_mem  [NUM_VOICES];
  logic [31:0] pos_mem  [NUM_VOICES];

  logic        in_range, in_stream, push_ok;
  logic [VI_W-1:0] v_idx;
  logic [SI_W-1:0] s_in, s_cur;
  logic        cur_stream;
  logic [RP_W-1:0] in_fill;

  assign in_range   = int'(voice_r) < NUM_VOICES;
  assign in_stream  = int'(voice_r) >= STREAM_FIRST;
  assign v_idx      = VI_W'(voice_r);
  assign s_in       = SI_W'(int'(voice_r) - STREAM_FIRST);
  assign s_cur      = SI_W'(int'(idx_r) - STREAM_FIRST);
  assign cur_stream = int'(idx_r) >= STREAM_FIRST;
  assign in_fill    = wr_ptr_r[s_in] - rd_ptr_r[s_in];
  assign push_ok    = in_range && in_stream && !in_fill[RP_W-1];

  // fetch side
  voice_t      vp_q;
  logic [31:0] pos_q;
  logic [15:0] pos0, pos1;
  logic [SA_W-1:0] sa0, sa1;
  logic [31:0] d0_q, d1_q, rq_q;
  logic [15:0] frac_r;

  assign pos0 = pos_q[31:16];
  assign pos1 = (17'(pos0) + 17'd1 < vp_q.len) ? pos0 + 16'd1 : pos0;
  assign sa0  = SA_W'(SUM_W'(vp_q.base) + SUM_W'(pos0));
  assign sa1  = SA_W'(SUM_W'(vp_q.base) + SUM_W'(pos1));

  // arithmetic registers
  logic signed [33:0] prod_l_r, prod_r_r;
  logic [31:0]        gp_l_r, gp_r_r;
  logic [33:0]        np_r, lenx;
  logic signed [15:0] sl_r, sr_r;
  logic signed [48:0] term_l_r, term_r_r;
  logic signed [ACC_W-1:0] acc_l_r, acc_r_r;

  assign lenx = {1'b0, vp_q.len, 16'd0};

  logic signed [16:0] dl, dr;
  logic signed [34:0] il, ir;
  assign dl = $signed({d1_q[15], d1_q[15:0]}) - $signed({d0_q[15], d0_q[15:0]});
  assign dr = $signed({d1_q[31], d1_q[31:16]}) - $signed({d0_q[31], d0_q[31:16]});
  assign il = $signed({d0_q[15], d0_q[15:0], 18'd0}) >>> 2;
  assign ir = $signed({d0_q[31], d0_q[31:16], 18'd0}) >>> 2;

  logic signed [34:0] rl, rr;
  assign rl = il + 35'(prod_l_r) + 35'sd32768;
  assign rr = ir + 35'(prod_r_r) + 35'sd32768;

  always_ff @(posedge clk) begin
    vp_q  <= par_mem[idx_r];
    pos_q <= pos_mem[idx_r];
    if (ctl.fetch) begin
      d0_q   <= smem[sa0];
      d1_q   <= smem[sa1];
      rq_q   <= ring[{s_cur, rd_ptr_r[s_cur][RA_W-1:0]}];
      frac_r <= pos_q[15:0];
    end
    if (ctl.lerp) begin
      prod_l_r <= dl * $signed({1'b0, frac_r});
      prod_r_r <= dr * $signed({1'b0, frac_r});
      gp_l_r   <= vp_q.gain * vp_q.pan_l;
      gp_r_r   <= vp_q.gain * vp_q.pan_r;
      np_r     <= 34'(pos_q) + 34'(vp_q.step);
    end else if (ctl.wrap && np_r >= lenx) begin
      np_r <= np_r - lenx;
    end
    if (ctl.round) begin
      if (cur_stream) begin
        sl_r <= rq_q[15:0];
        sr_r <= rq_q[31:16];
      end else begin
        sl_r <= rl[31:16];
        sr_r <= stereo_r[idx_r] ? rr[31:16] : rl[31:16];
      end
    end
    if (ctl.mul) begin
      term_l_r <= sl_r * $signed({1'b0, gp_l_r});
      term_r_r <= sr_r * $signed({1'b0, gp_r_r});
    end
    if (ctl.mix_init) begin
      acc_l_r <= '0;
      acc_r_r <= '0;
    end else if (ctl.acc) begin
      acc_l_r <= acc_l_r + ACC_W'(term_l_r);
      acc_r_r <= acc_r_r + ACC_W'(term_r_r);
    end
  end

  // memory writes
  logic        pw_en;
  logic [VI_W-1:0] pw_addr;
  logic [31:0] pw_data;
  logic        over, wrap_more;
  voice_t      par_new;

  assign over      = np_r >= lenx;
  assign wrap_more = np_r >= lenx;

  always_comb begin
    par_new.base  = addr_r;
    par_new.len   = (len_r > 17'd65536) ? 17'd65536 : len_r;
    par_new.step  = step_r;
    par_new.gain  = gain_r;
    par_new.pan_l = panl_r;
    par_new.pan_r = panr_r;
    pw_en   = 1'b0;
    pw_addr = idx_r;
    pw_data = np_r[31:0];
    priority if (ctl.exec && cmd_r == CMD_START && in_range && !in_stream) begin
      pw_en   = 1'b1;
      pw_addr = v_idx;
      pw_data = '0;
    end else if (ctl.acc && !cur_stream && !(over && loop_r[idx_r])) begin
      pw_en   = 1'b1;
      pw_data = over ? 32'd0 : np_r[31:0];
    end else if (ctl.wrap && !wrap_more) begin
      pw_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pw_en) begin
      pos_mem[pw_addr] <= pw_data;
    end
    if (ctl.exec && cmd_r == CMD_START && in_range) begin
      par_mem[v_idx] <= par_new;
    end
    if (ctl.exec && cmd_r == CMD_WRITE) begin
      smem[SA_W'(addr_r)] <= {right_r, left_r};
    end
    if (ctl.exec && cmd_r == CMD_PUSH && push_ok) begin
      ring[{s_in, wr_ptr_r[s_in][RA_W-1:0]}] <=
        {(stereo_in_r ? right_r : left_r), left_r};
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      play_r   <= '0;
      stereo_r <= '0;
      loop_r   <= '0;
      stop_r   <= '0;
      cnt_r    <= '0;
      idx_r    <= '0;
      for (int i = 0; i < STREAM_N; i++) begin
        rd_ptr_r[i] <= '0;
        wr_ptr_r[i] <= '0;
      end
    end else begin
      if (ctl.exec) begin
        priority case (cmd_r)
          CMD_START: begin
            if (in_range) begin
              if (!play_r[v_idx]) begin
                cnt_r <= cnt_r + CNT_W'(1);
              end
              play_r[v_idx]   <= 1'b1;
              stop_r[v_idx]   <= 1'b0;
              stereo_r[v_idx] <= !in_stream && stereo_in_r;
              loop_r[v_idx]   <= !in_stream && loop_in_r;
              if (in_stream) begin
                rd_ptr_r[s_in] <= '0;
                wr_ptr_r[s_in] <= '0;
              end
            end
          end
          CMD_STOP: begin
            if (in_range) begin
              if (in_stream) begin
                stop_r[v_idx] <= 1'b1;
              end else if (play_r[v_idx]) begin
                play_r[v_idx] <= 1'b0;
                cnt_r         <= cnt_r - CNT_W'(1);
              end
            end
          end
          CMD_PUSH: begin
            if (push_ok) begin
              wr_ptr_r[s_in] <= wr_ptr_r[s_in] + RP_W'(1);
            end
          end
          default: begin
          end
        endcase
      end
      if (ctl.end_voice) begin
        play_r[idx_r] <= 1'b0;
        cnt_r         <= cnt_r - CNT_W'(1);
      end
      if (ctl.acc && cur_stream) begin
        rd_ptr_r[s_cur] <= rd_ptr_r[s_cur] + RP_W'(1);
      end
      if (ctl.mix_init) begin
        idx_r <= '0;
      end else if (ctl.next_voice) begin
        idx_r <= idx_r + VI_W'(1);
      end
    end
  end

  assign stat.cmd       = cmd_r;
  assign stat.play      = play_r[idx_r];
  assign stat.stream    = cur_stream;
  assign stat.ended     = 17'(pos0) >= vp_q.len;
  assign stat.empty     = rd_ptr_r[s_cur] == wr_ptr_r[s_cur];
  assign stat.stop_req  = stop_r[idx_r];
  assign stat.last      = idx_r == VI_W'(NUM_VOICES - 1);
  assign stat.over      = over;
  assign stat.loop      = loop_r[idx_r];
  assign stat.wrap_more = wrap_more;

  // rounding and saturation
  logic signed [ACC_W:0] lsum, rsum;
  logic        lclip, rclip;
  assign lsum  = $signed({acc_l_r[ACC_W-1], acc_l_r}) + (ACC_W+1)'(2**28);
  assign rsum  = $signed({acc_r_r[ACC_W-1], acc_r_r}) + (ACC_W+1)'(2**28);
  assign lclip = !((&lsum[ACC_W:44]) || !(|lsum[ACC_W:44]));
  assign rclip = !((&rsum[ACC_W:44]) || !(|rsum[ACC_W:44]));

  logic               valid_r, clip_r;
  logic signed [15:0] ml_r, mr_r;
  logic [1:0]         status_r;
  logic [6:0]         active_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= ctl.emit || (ctl.exec && cmd_r == CMD_PUSH);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      ml_r     <= lclip ? (lsum[ACC_W] ? 16'sh8000 : 16'sh7fff) : lsum[44:29];
      mr_r     <= rclip ? (rsum[ACC_W] ? 16'sh8000 : 16'sh7fff) : rsum[44:29];
      clip_r   <= lclip || rclip;
      status_r <= STAT_MIXED;
      active_r <= 7'(cnt_r);
    end else if (ctl.exec && cmd_r == CMD_PUSH) begin
      ml_r     <= '0;
      mr_r     <= '0;
      clip_r   <= 1'b0;
      status_r <= push_ok ? STAT_PUSHED : STAT_DROPPED;
      active_r <= 7'(cnt_r);
    end
  end

  assign out_valid         = valid_r;
  assign out_mix_left      = ml_r;
  assign out_mix_right     = mr_r;
  assign out_clipped       = clip_r;
  assign out_active_voices = active_r;
  assign out_status        = status_r;

  `MVM_ASSERT(a_count_matches, clk, rst_n, cnt_r == CNT_W'($countones(play_r)))
  `MVM_ASSERT(a_single_strobe, clk, rst_n, valid_r |=> !valid_r)

endmodule
`default_nettype wire

// ===== rtl/multi_voice_audio_mixer.sv =====
// Mixer top: write, start, stop and push go from idle to execute and back; a push
// item's result strobe is registered from its execute state. A mix visits every
// voice: fetch, lerp, round, mul and acc for a mixed voice, fetch alone for an ended
// voice or empty stream, and up to 8 length subtractions for a looping voice's wrap.
// Synchronous active-low reset clears voice flags, ring pointers and the count;
// sample and ring memories hold garbage until written.
`default_nettype none
module multi_voice_audio_mixer #(
  parameter int NUM_VOICES    = mvm_pkg::NUM_VOICES_DEF,
  parameter int STREAM_VOICES = mvm_pkg::STREAM_VOICES_DEF,
  parameter int RING_FRAMES   = mvm_pkg::RING_FRAMES_DEF,
  parameter int SAMPLE_FRAMES = mvm_pkg::SAMPLE_FRAMES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         in_cmd,
  input  logic [5:0]         in_voice,
  input  logic [15:0]        in_address,
  input  logic signed [15:0] in_sample_left,
  input  logic signed [15:0] in_sample_right,
  input  logic [16:0]        in_length_frames,
  input  logic [18:0]        in_step,
  input  logic [15:0]        in_gain,
  input  logic [15:0]        in_pan_left,
  input  logic [15:0]        in_pan_right,
  input  logic               in_stereo,
  input  logic               in_looping,
  output logic               out_valid,
  output logic signed [15:0] out_mix_left,
  output logic signed [15:0] out_mix_right,
  output logic               out_clipped,
  output logic [6:0]         out_active_voices,
  output logic [1:0]         out_status
);
  import mvm_pkg::*;

  dp_ctl_t  ctl;
  dp_stat_t stat;

  mvm_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .ctl   (ctl),
    .stat  (stat)
  );

  mvm_dp #(
    .NUM_VOICES    (NUM_VOICES),
    .STREAM_VOICES (STREAM_VOICES),
    .RING_FRAMES   (RING_FRAMES),
    .SAMPLE_FRAMES (SAMPLE_FRAMES)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .ctl               (ctl),
    .stat              (stat),
    .in_cmd            (in_cmd),
    .in_voice          (in_voice),
    .in_address        (in_address),
    .in_sample_left    (in_sample_left),
    .in_sample_right   (in_sample_right),
    .in_length_frames  (in_length_frames),
    .in_step           (in_step),
    .in_gain           (in_gain),
    .in_pan_left       (in_pan_left),
    .in_pan_right      (in_pan_right),
    .in_stereo         (in_stereo),
    .in_looping        (in_looping),
    .out_valid         (out_valid),
    .out_mix_left      (out_mix_left),
    .out_mix_right     (out_mix_right),
    .out_clipped       (out_clipped),
    .out_active_voices (out_active_voices),
    .out_status        (out_status)
  );

endmodule
`default_nettype wire
